// ===== src/lphi_pkg.sv =====
// ----------------------------------------------------------------------------
// lphi_pkg
// Shared types and constants for the linear probing hash insert block.
// ----------------------------------------------------------------------------
package lphi_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int CAP_W       = 11;
  localparam int CNT_W       = 11;
  localparam int KEY_W       = 64;
  localparam int OFF_W       = 64;
  localparam int SIZE_W      = 32;
  localparam int BITCNT_W    = $clog2(KEY_W);

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    ST_NEW      = 2'd0,
    ST_UPDATED  = 2'd1,
    ST_FULL     = 2'd2,
    ST_NO_TABLE = 2'd3
  } status_t;

  // one table slot as stored in RAM
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [OFF_W-1:0]  offset;
    logic [SIZE_W-1:0] size;
    logic              baked;
    logic              attractor;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller -> datapath
  typedef struct packed {
    logic clr;       // write one zero entry of the clearing pass
    logic load;      // capture accepted request
    logic div;       // one remainder step
    logic chk;       // evaluate probed slot
    logic out_load;  // move result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic cap_zero;
    logic div_last;
    logic hit;
    logic wrap;
    logic out_free;
  } sts_t;

endpackage

// ===== src/linear_probe_hash_insert.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_insert
// Open-addressing hash table insert-or-update with linear probing.
// ----------------------------------------------------------------------------
// Input channel (in_*): one request carries key, sector offset, payload size
// and attractor flag; accepted when in_valid is high and in_stall low.
// Result channel (out_*): one result per request with slot index, status
// (new, updated, full, no table) and the live entry count after the insert.
// cfg_we/cfg_wdata write the table capacity; write only while idle.
// Steps: accept, the bit-serial key remainder, then per probed slot a RAM
// read and a compare/write, then the move into the output register. With
// capacity zero the remainder and the probes are skipped.
// One request is in work at a time; the remainder loop and the single RAM
// port set the rate. A new request is taken while a result waits in the
// output register.
// Reset: capacity 1024, count 0, then a clearing pass writes all 1024 slots
// with in_stall high.
// When out_stall is high the result holds; a finished next result waits
// inside until the output register frees.
// ----------------------------------------------------------------------------
module linear_probe_hash_insert (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lphi_pkg::CAP_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lphi_pkg::KEY_W-1:0]    in_key,
  input  logic [lphi_pkg::OFF_W-1:0]    in_sector_offset,
  input  logic [lphi_pkg::SIZE_W-1:0]   in_payload_bytes,
  input  logic                          in_attractor,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lphi_pkg::SLOT_W-1:0]   out_slot_index,
  output logic [1:0]                    out_status,
  output logic [lphi_pkg::CNT_W-1:0]    out_occupied_count
);

  import lphi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lphi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lphi_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_key             (in_key),
    .in_sector_offset   (in_sector_offset),
    .in_payload_bytes   (in_payload_bytes),
    .in_attractor       (in_attractor),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_slot_index     (out_slot_index),
    .out_status         (out_status),
    .out_occupied_count (out_occupied_count),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule

// ===== src/lphi_ram.sv =====
// ----------------------------------------------------------------------------
// lphi_ram
// Generic single-port RAM, one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
module lphi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/lphi_ctrl.sv =====
// ----------------------------------------------------------------------------
// lphi_ctrl
// Sequencer: clearing pass, request accept, remainder steps, probe loop,
// result handoff.
// ----------------------------------------------------------------------------
module lphi_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  lphi_pkg::sts_t sts,
  output lphi_pkg::cmd_t cmd
);

  import lphi_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.cap_zero ? S_DONE : S_DIV;
        end
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (sts.div_last) state_nxt = S_PROBE_RD;
      end
      S_PROBE_RD: begin
        state_nxt = S_PROBE_CHK;
      end
      S_PROBE_CHK: begin
        cmd.chk   = 1'b1;
        state_nxt = (sts.hit || sts.wrap) ? S_DONE : S_PROBE_RD;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == S_IDLE) && in_valid)
    else $error("request captured outside idle");
  a_div_to_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && sts.div_last |=> (state_r == S_PROBE_RD))
    else $error("remainder done but probe did not start");
  a_clear_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) && !sts.clr_last |=> (state_r == S_CLEAR))
    else $error("clearing pass left early");
`endif

endmodule

// ===== src/lphi_dp.sv =====
// ----------------------------------------------------------------------------
// lphi_dp
// Datapath: capacity register, bit-serial remainder, probe pointer, slot RAM,
// live count and output register.
// ----------------------------------------------------------------------------
module lphi_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lphi_pkg::CAP_W-1:0]    cfg_wdata,
  input  logic [lphi_pkg::KEY_W-1:0]    in_key,
  input  logic [lphi_pkg::OFF_W-1:0]    in_sector_offset,
  input  logic [lphi_pkg::SIZE_W-1:0]   in_payload_bytes,
  input  logic                          in_attractor,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lphi_pkg::SLOT_W-1:0]   out_slot_index,
  output logic [1:0]                    out_status,
  output logic [lphi_pkg::CNT_W-1:0]    out_occupied_count,
  input  lphi_pkg::cmd_t                cmd,
  output lphi_pkg::sts_t                sts
);

  import lphi_pkg::*;

  // control state
  logic [CAP_W-1:0]    cap_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [SLOT_W-1:0]   clr_cnt_r;
  logic                out_valid_r;

  // request and work registers
  logic [KEY_W-1:0]    key_r;
  logic [OFF_W-1:0]    off_r;
  logic [SIZE_W-1:0]   size_r;
  logic                attr_r;
  logic [KEY_W-1:0]    div_r;
  logic [BITCNT_W-1:0] bit_cnt_r;
  logic [SLOT_W-1:0]   rem_r;
  logic [SLOT_W-1:0]   start_r;
  logic [SLOT_W-1:0]   slot_r;

  // pending result and output register
  logic [SLOT_W-1:0]   res_slot_r;
  status_t             res_status_r;
  logic [CNT_W-1:0]    res_cnt_r;
  logic [SLOT_W-1:0]   o_slot_r;
  status_t             o_status_r;
  logic [CNT_W-1:0]    o_cnt_r;

  logic [CAP_W-1:0]    cap_eff;
  logic [CAP_W-1:0]    trial;
  logic [CAP_W-1:0]    trial_sub;
  logic [SLOT_W-1:0]   rem_nxt;
  logic [CAP_W-1:0]    nxt_wide;
  logic [SLOT_W-1:0]   nxt_slot;
  logic [CNT_W-1:0]    cnt_inc;
  logic                slot_empty;
  logic                hit;
  logic                ram_we;
  logic [SLOT_W-1:0]   ram_addr;
  entry_t              ram_wdata;
  entry_t              ram_rdata;

  assign cap_eff = (cap_r > CAP_W'(TABLE_DEPTH)) ? CAP_W'(TABLE_DEPTH) : cap_r;

  // restoring remainder, one key bit per step; remainder stays below cap
  assign trial     = {rem_r, div_r[KEY_W-1]};
  assign trial_sub = trial - cap_eff;
  assign rem_nxt   = (trial >= cap_eff) ? trial_sub[SLOT_W-1:0] : trial[SLOT_W-1:0];

  assign nxt_wide = CAP_W'(slot_r) + CAP_W'(1);
  assign nxt_slot = (nxt_wide >= cap_eff) ? '0 : nxt_wide[SLOT_W-1:0];

  assign slot_empty = (ram_rdata.key == '0);
  assign hit        = slot_empty || (ram_rdata.key == key_r);
  assign cnt_inc    = (cnt_r != COUNT_MAX) ? cnt_r + CNT_W'(1) : cnt_r;

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = slot_r;
    ram_wdata = '0;
    if (cmd.clr) begin
      ram_we   = 1'b1;
      ram_addr = clr_cnt_r;
    end else if (cmd.chk && hit) begin
      ram_we              = 1'b1;
      ram_wdata.key       = key_r;
      ram_wdata.offset    = off_r;
      ram_wdata.size      = size_r;
      ram_wdata.baked     = 1'b1;
      ram_wdata.attractor = attr_r;
    end
  end

  lphi_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_W'(TABLE_DEPTH);
      cnt_r       <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) cap_r <= cfg_wdata;
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + SLOT_W'(1);
      if (cmd.chk && hit && slot_empty) cnt_r <= cnt_inc;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r        <= in_key;
      off_r        <= in_sector_offset;
      size_r       <= in_payload_bytes;
      attr_r       <= in_attractor;
      div_r        <= in_key;
      rem_r        <= '0;
      bit_cnt_r    <= BITCNT_W'(KEY_W - 1);
      res_slot_r   <= '0;
      res_status_r <= ST_NO_TABLE;
      res_cnt_r    <= cnt_r;
    end
    if (cmd.div) begin
      div_r     <= {div_r[KEY_W-2:0], 1'b0};
      rem_r     <= rem_nxt;
      bit_cnt_r <= bit_cnt_r - BITCNT_W'(1);
      if (bit_cnt_r == '0) begin
        start_r <= rem_nxt;
        slot_r  <= rem_nxt;
      end
    end
    if (cmd.chk) begin
      if (hit) begin
        res_slot_r   <= slot_r;
        res_status_r <= slot_empty ? ST_NEW : ST_UPDATED;
        res_cnt_r    <= slot_empty ? cnt_inc : cnt_r;
      end else if (nxt_slot == start_r) begin
        res_slot_r   <= slot_r;
        res_status_r <= ST_FULL;
        res_cnt_r    <= cnt_r;
      end else begin
        slot_r <= nxt_slot;
      end
    end
    if (cmd.out_load) begin
      o_slot_r   <= res_slot_r;
      o_status_r <= res_status_r;
      o_cnt_r    <= res_cnt_r;
    end
  end

  assign sts.clr_last = (clr_cnt_r == SLOT_W'(TABLE_DEPTH - 1));
  assign sts.cap_zero = (cap_eff == '0);
  assign sts.div_last = (bit_cnt_r == '0);
  assign sts.hit      = hit;
  assign sts.wrap     = (nxt_slot == start_r);
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid          = out_valid_r;
  assign out_slot_index     = o_slot_r;
  assign out_status         = o_status_r;
  assign out_occupied_count = o_cnt_r;

`ifndef SYNTHESIS
  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cnt_r >= $past(cnt_r))
    else $error("live count went down");
  a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.chk |-> (CAP_W'(slot_r) < cap_eff))
    else $error("probe outside capacity");
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a stalled one");
`endif

endmodule

// ===== test/lphi_insert_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphi_insert_checker
// Watches the request, result and capacity ports of the hash insert block.
// Keeps its own copy of the slot table, live count and capacity, works out
// the slot, status and count for every accepted request, and compares each
// accepted result with the oldest outcome still waiting.
// ----------------------------------------------------------------------------
module lphi_insert_checker
  import lphi_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CAP_W-1:0]    cfg_wdata,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [OFF_W-1:0]    in_sector_offset,
  input  logic [SIZE_W-1:0]   in_payload_bytes,
  input  logic                in_attractor,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [SLOT_W-1:0]   out_slot_index,
  input  logic [1:0]          out_status,
  input  logic [CNT_W-1:0]    out_occupied_count,
  output int                  errors,
  output int                  pending,
  output bit                  count_saturated,
  output int                  n_new,
  output int                  n_updated,
  output int                  n_full,
  output int                  n_no_table
);

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    status_t           status;
    logic [CNT_W-1:0]  count;
  } insert_outcome_t;

  entry_t            slot_tbl [TABLE_DEPTH];
  logic [CNT_W-1:0]  live;
  logic [CAP_W-1:0]  capacity;
  insert_outcome_t   outcome_q [$];

  task automatic place_key(input logic [KEY_W-1:0] key, input logic [OFF_W-1:0] off,
                           input logic [SIZE_W-1:0] bytes, input logic attr);
    logic [CAP_W-1:0] cap_eff;
    logic [KEY_W-1:0] rem;
    int unsigned      home;
    int unsigned      slot;
    int unsigned      nxt;
    bit               full;
    insert_outcome_t  o;
    cap_eff = (capacity > TABLE_DEPTH) ? CAP_W'(TABLE_DEPTH) : capacity;
    if (cap_eff == '0) begin
      o.slot   = '0;
      o.status = ST_NO_TABLE;
      o.count  = live;
    end else begin
      rem  = key % {{(KEY_W-CAP_W){1'b0}}, cap_eff};
      home = int'(rem[CAP_W-1:0]);
      slot = home;
      full = 1'b0;
      while (!full && slot_tbl[slot].key != '0 && slot_tbl[slot].key != key) begin
        nxt = (slot + 1 >= cap_eff) ? 0 : slot + 1;
        if (nxt == home) full = 1'b1;
        else slot = nxt;
      end
      o.slot = SLOT_W'(slot);
      if (full) begin
        o.status = ST_FULL;
      end else begin
        if (slot_tbl[slot].key == '0) begin
          o.status = ST_NEW;
          if (live != COUNT_MAX) live = live + 1'b1;
        end else begin
          o.status = ST_UPDATED;
        end
        // a zero key is written too, so the slot still reads as empty
        slot_tbl[slot].key       = key;
        slot_tbl[slot].offset    = off;
        slot_tbl[slot].size      = bytes;
        slot_tbl[slot].baked     = 1'b1;
        slot_tbl[slot].attractor = attr;
      end
      o.count = live;
    end
    outcome_q.push_back(o);
  endtask

  always @(posedge clk) begin
    insert_outcome_t exp_o;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) slot_tbl[i] = '0;
      live     = '0;
      capacity = CAP_W'(TABLE_DEPTH);
      outcome_q.delete();
    end else begin
      if (cfg_we) capacity = cfg_wdata;
      // results first: a result never belongs to a request taken at the same edge
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          $error("result with no request waiting: slot_index %0d status %0d count %0d",
                 out_slot_index, out_status, out_occupied_count);
          errors++;
        end else begin
          exp_o = outcome_q.pop_front();
          if (out_slot_index !== exp_o.slot) begin
            $error("slot_index: expected %0d, actual %0d", exp_o.slot, out_slot_index);
            errors++;
          end
          if (out_status !== exp_o.status) begin
            $error("status: expected %0d, actual %0d", exp_o.status, out_status);
            errors++;
          end
          if (out_occupied_count !== exp_o.count) begin
            $error("occupied_count: expected %0d, actual %0d", exp_o.count,
                   out_occupied_count);
            errors++;
          end
          case (exp_o.status)
            ST_NEW:     n_new++;
            ST_UPDATED: n_updated++;
            ST_FULL:    n_full++;
            default:    n_no_table++;
          endcase
        end
      end
      if (in_valid && !in_stall)
        place_key(in_key, in_sector_offset, in_payload_bytes, in_attractor);
    end
    pending         = outcome_q.size();
    count_saturated = (live == COUNT_MAX);
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the linear probing hash insert block.
// Directed requests hit the wrap, zero-key, full-table, no-table and
// capacity-saturation corners; random phases then fill large and small
// tables with new keys, repeats and zero keys, and a last phase pushes the
// live count up with mostly zero keys. Sender bursts, receiver stalls and
// two long result hold-offs vary the flow; the checker beside the block does
// the rest.
// ----------------------------------------------------------------------------
module tb_top;
  import lphi_pkg::*;

  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 100;

  typedef enum int {STALL_NONE, STALL_HALF, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

  logic                clk;
  logic                rst_n            = 1'b0;
  logic                cfg_we           = 1'b0;
  logic [CAP_W-1:0]    cfg_wdata        = '0;
  logic                in_valid         = 1'b0;
  logic [KEY_W-1:0]    in_key           = '0;
  logic [OFF_W-1:0]    in_sector_offset = '0;
  logic [SIZE_W-1:0]   in_payload_bytes = '0;
  logic                in_attractor     = 1'b0;
  logic                out_stall        = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [SLOT_W-1:0]   out_slot_index;
  logic [1:0]          out_status;
  logic [CNT_W-1:0]    out_occupied_count;

  int                  errors;
  int                  pending;
  bit                  count_saturated;
  int                  n_new;
  int                  n_updated;
  int                  n_full;
  int                  n_no_table;

  int                  burst_left;
  int                  n_sent;
  int                  n_cap_writes;
  int                  quiet_cycles;
  logic                hold_off_req = 1'b0;
  logic [KEY_W-1:0]    key_pool [$];

  linear_probe_hash_insert i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_key             (in_key),
    .in_sector_offset   (in_sector_offset),
    .in_payload_bytes   (in_payload_bytes),
    .in_attractor       (in_attractor),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_slot_index     (out_slot_index),
    .out_status         (out_status),
    .out_occupied_count (out_occupied_count)
  );

  lphi_insert_checker i_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_key             (in_key),
    .in_sector_offset   (in_sector_offset),
    .in_payload_bytes   (in_payload_bytes),
    .in_attractor       (in_attractor),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_slot_index     (out_slot_index),
    .out_status         (out_status),
    .out_occupied_count (out_occupied_count),
    .errors             (errors),
    .pending            (pending),
    .count_saturated    (count_saturated),
    .n_new              (n_new),
    .n_updated          (n_updated),
    .n_full             (n_full),
    .n_no_table         (n_no_table)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // mix of zero keys, repeats of earlier keys, small colliding keys and wide keys
  function automatic logic [KEY_W-1:0] pick_key(int unsigned small_max);
    int unsigned      r;
    logic [KEY_W-1:0] k;
    r = $urandom_range(0, 99);
    if (r < 5) k = '0;
    else if (r < 35 && key_pool.size() != 0)
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    else if (r < 55) k = KEY_W'($urandom_range(1, small_max));
    else k = rand64();
    if (k != '0 && r >= 35) begin
      key_pool.push_back(k);
      if (key_pool.size() > 256) void'(key_pool.pop_front());
    end
    return k;
  endfunction

  task automatic send_request(input logic [KEY_W-1:0] key, input logic [OFF_W-1:0] off,
                              input logic [SIZE_W-1:0] bytes, input logic attr);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 160)
                                               : $urandom_range(1, 24);
    end
    in_valid         <= 1'b1;
    in_key           <= key;
    in_sector_offset <= off;
    in_payload_bytes <= bytes;
    in_attractor     <= attr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    n_sent++;
  endtask

  task automatic offer_random(input logic [KEY_W-1:0] key);
    send_request(key, rand64(), $urandom(), 1'($urandom_range(0, 1)));
  endtask

  // stop offering and wait until every request has its result
  task automatic drain_requests();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input int unsigned cap);
    drain_requests();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CAP_W'(cap);
    @(posedge clk);
    cfg_we    <= 1'b0;
    n_cap_writes++;
  endtask

  initial begin : stimulus
    int unsigned cap;
    int unsigned n;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // default capacity after reset: extremes, update, wrap past the top slot
    send_request('1, '1, '1, 1'b1);
    send_request('1, '0, '0, 1'b0);
    offer_random(64'd2047);
    // zero key lands in an empty slot, counts, and leaves it empty
    offer_random(64'd0);
    offer_random(64'd0);
    offer_random(64'd1);
    offer_random(64'h8000_0000_0000_0000);
    // capacity above the table depth behaves as the full depth
    set_capacity(2047);
    offer_random(64'd3071);
    set_capacity(TABLE_DEPTH + 1);
    offer_random(64'd1024);
    set_capacity(0);
    offer_random('1);
    offer_random(64'd0);
    // shrunken tables that are already full of other keys
    set_capacity(1);
    offer_random(64'd7);
    offer_random(64'd2047);
    set_capacity(3);
    offer_random(64'd5);
    offer_random(64'h8000_0000_0000_0000);
    set_capacity(2);
    offer_random(64'd3);
    set_capacity(TABLE_DEPTH);
    offer_random(64'd1024);

    // full-size table, with a long result hold-off partway through
    for (int i = 0; i < 320; i++) begin
      if (i == 100) hold_off_req = 1'b1;
      offer_random(pick_key(4096));
    end

    // small tables driven past full
    for (int r = 0; r < 10; r++) begin
      cap = (r < 2) ? r + 1 : $urandom_range(3, 40);
      set_capacity(cap);
      n = 2 * cap + $urandom_range(2, 12);
      repeat (n) offer_random(pick_key(200));
    end

    // assorted capacities, including none and above depth
    for (int r = 0; r < 10; r++) begin
      case ($urandom_range(0, 4))
        0:       cap = 0;
        1:       cap = TABLE_DEPTH;
        2:       cap = $urandom_range(TABLE_DEPTH + 1, 2047);
        default: cap = $urandom_range(41, TABLE_DEPTH - 1);
      endcase
      set_capacity(cap);
      repeat (30) offer_random(pick_key(4096));
    end

    // mostly zero keys to push the live count up
    set_capacity(TABLE_DEPTH);
    hold_off_req = 1'b1;
    repeat (300)
      offer_random(($urandom_range(0, 19) == 0) ? pick_key(4096) : 64'd0);
    repeat (30) offer_random(($urandom_range(0, 3) == 0) ? pick_key(4096) : 64'd0);

    drain_requests();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d requests across %0d capacity writes; live count ceiling reached: %s",
             n_sent, n_cap_writes, count_saturated ? "yes" : "no");
    $display("results: %0d new, %0d updated, %0d full, %0d no table",
             n_new, n_updated, n_full, n_no_table);
    if (errors == 0 && pending == 0) begin
      $display("linear_probe_hash_insert: match");
    end else begin
      if (pending != 0) $error("%0d results never arrived", pending);
      $display("linear_probe_hash_insert: mismatch");
    end
    $finish;
  end

  // result side: random stall patterns, plus a long hold-off on request
  initial begin : receiver
    stall_mode_t mode;
    int          run_left;
    mode     = STALL_NONE;
    run_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else begin
        if (run_left == 0) begin
          mode     = stall_mode_t'($urandom_range(0, 3));
          run_left = $urandom_range(4, 64);
        end
        run_left--;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_HALF:  out_stall <= 1'($urandom_range(0, 1));
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          default:     out_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no request or result moved for %0d cycles", WATCHDOG_LIMIT);
      $display("linear_probe_hash_insert: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== filelist.f =====
src/lphi_pkg.sv
src/lphi_ram.sv
src/lphi_ctrl.sv
src/lphi_dp.sv
src/linear_probe_hash_insert.sv
test/lphi_insert_checker.sv
test/tb_top.sv
